@@ hw/rtl/lse_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lse_pkg
// Shared codes and field widths for the LSB steganography embedder.
// ----------------------------------------------------------------------------
package lse_pkg;

  localparam int unsigned KindW    = 2;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned NibbleW  = 4;
  localparam int unsigned FlagIdxW = 2;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned NumPat   = 4;
  localparam int unsigned SlotW    = 3;

  // Item kinds.
  localparam logic [KindW-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KindW-1:0] KIND_SCAN  = 2'd1;
  localparam logic [KindW-1:0] KIND_FLAG  = 2'd2;
  localparam logic [KindW-1:0] KIND_EMBED = 2'd3;

  // Embedding modes; the unused code behaves as one-bit LSB.
  localparam logic [ModeW-1:0] MODE_LSB1 = 2'd0;
  localparam logic [ModeW-1:0] MODE_LSB4 = 2'd1;
  localparam logic [ModeW-1:0] MODE_LSBI = 2'd2;

  localparam logic [ByteW-1:0] MASK_BIT0  = 8'hFE;
  localparam logic [ByteW-1:0] MASK_NIB   = 8'hF0;
  localparam logic [NibbleW-1:0] MASK_LOW = 4'hF;

endpackage : lse_pkg
`default_nettype wire

@@ hw/rtl/lse_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lse_in_if
// Valid/ready channel that carries one cover item into the embedder.
// ----------------------------------------------------------------------------
interface lse_in_if
  import lse_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [KindW-1:0]    kind;
  logic [ByteW-1:0]    cover_byte;
  logic [NibbleW-1:0]  payload_bits;
  logic [FlagIdxW-1:0] flag_index;

  modport source (
    output valid, kind, cover_byte, payload_bits, flag_index,
    input  ready
  );

  modport sink (
    input  valid, kind, cover_byte, payload_bits, flag_index,
    output ready
  );
endinterface : lse_in_if
`default_nettype wire

@@ hw/rtl/lse_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lse_out_if
// Valid/ready channel that carries one stego item out of the embedder.
// ----------------------------------------------------------------------------
interface lse_out_if
  import lse_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [ByteW-1:0]   stego_byte;
  logic [NibbleW-1:0] flags_now;

  modport source (
    output valid, stego_byte, flags_now,
    input  ready
  );

  modport sink (
    input  valid, stego_byte, flags_now,
    output ready
  );
endinterface : lse_out_if
`default_nettype wire

@@ hw/rtl/lsb_stego_embedder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsb_stego_embedder
// Hides payload bits in cover bytes with one-bit LSB, four-bit LSB or LSBI.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless a result item waits untaken. An
// accepted item sits in the input register and moves to the result register when
// that register can take it and is offered there; an item with a result waits
// in the input register only while the result register holds an untaken item.
// Clear and scan items update the eight saturating pattern counters and return
// nothing. Flag items latch the four inversion flags from the counter
// comparisons and return the cover byte with the selected flag in bit 0. Embed
// items return the cover byte with the payload written per the mode. Write the
// mode only while no item is in flight.
module lsb_stego_embedder
  import lse_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [ModeW-1:0] cfg_wdata_i,
  lse_in_if.sink                in_i,
  lse_out_if.source             out_o
);

  logic [ModeW-1:0] mode_q;

  logic                s1_valid_q;
  logic [KindW-1:0]    s1_kind_q;
  logic [ByteW-1:0]    s1_cover_q;
  logic [NibbleW-1:0]  s1_payload_q;
  logic [FlagIdxW-1:0] s1_fidx_q;

  logic [COUNT_BITS-1:0] count_q [2*NumPat];
  logic [NumPat-1:0]     flags_q;
  logic [NumPat-1:0]     flags_d;

  logic               out_valid_q;
  logic [ByteW-1:0]   out_byte_q;
  logic [NibbleW-1:0] out_flags_q;

  logic               has_result;
  logic               s1_fire;
  logic               in_fire;
  logic [1:0]         pattern;
  logic               pbit;
  logic [SlotW-1:0]   scan_slot;
  logic [ByteW-1:0]   res_byte;
  logic [NumPat-1:0]  cmp_flags;

  assign has_result = (s1_kind_q == KIND_FLAG) || (s1_kind_q == KIND_EMBED);
  assign s1_fire    = s1_valid_q && (!has_result || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_fire    = in_i.valid && in_i.ready;

  assign pattern   = s1_cover_q[2:1];
  assign pbit      = s1_payload_q[0];
  assign scan_slot = {pattern, s1_cover_q[0] ^ pbit};

  always_comb begin
    for (int p = 0; p < NumPat; p++) begin
      cmp_flags[p] = count_q[2*p+1] > count_q[2*p];
    end
  end

  always_comb begin
    flags_d  = flags_q;
    res_byte = (s1_cover_q & MASK_BIT0) | {{(ByteW-1){1'b0}}, pbit};
    unique case (s1_kind_q)
      KIND_FLAG: begin
        flags_d  = cmp_flags;
        res_byte = (s1_cover_q & MASK_BIT0) | {{(ByteW-1){1'b0}}, cmp_flags[s1_fidx_q]};
      end
      KIND_EMBED: begin
        if (mode_q == MODE_LSB4) begin
          res_byte = (s1_cover_q & MASK_NIB) | {{(ByteW-NibbleW){1'b0}}, s1_payload_q & MASK_LOW};
        end else if (mode_q == MODE_LSBI) begin
          res_byte = (s1_cover_q & MASK_BIT0)
                   | {{(ByteW-1){1'b0}}, pbit ^ flags_q[pattern]};
        end
      end
      KIND_CLEAR, KIND_SCAN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_LSB1;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q    <= in_i.kind;
      s1_cover_q   <= in_i.cover_byte;
      s1_payload_q <= in_i.payload_bits;
      s1_fidx_q    <= in_i.flag_index;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < 2*NumPat; c++) begin
        count_q[c] <= '0;
      end
      flags_q <= '0;
    end else if (s1_fire) begin
      for (int c = 0; c < 2*NumPat; c++) begin
        if (s1_kind_q == KIND_CLEAR) begin
          count_q[c] <= '0;
        end else if ((s1_kind_q == KIND_SCAN) && (scan_slot == SlotW'(c))
                     && (count_q[c] != '1)) begin
          count_q[c] <= count_q[c] + 1'b1;
        end
      end
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && has_result) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && has_result) begin
      out_byte_q  <= res_byte;
      out_flags_q <= flags_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.stego_byte = out_byte_q;
  assign out_o.flags_now  = out_flags_q;

endmodule : lsb_stego_embedder
`default_nettype wire

@@ hw/rtl/lse_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lse_checker
// Port-level checks for the LSB steganography embedder.
// ----------------------------------------------------------------------------
module lse_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i
);

  // A result stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Result item dropped before it was taken.");

  // The input side stalls only behind a full result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("Input stalled while no result was waiting.");

  // Right after reset the block is empty and ready.
  assert property (@(posedge clk_i)
    rst_ni && !$past(rst_ni) |-> in_ready_i && !out_valid_i)
    else $error("Block not empty after reset.");

  // An input item waiting at a stall must still be offered in the next cycle unless the block is then ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |=> in_valid_i || in_ready_i)
    else $error("Input handshake broken during a stall.");

endmodule : lse_checker

bind lsb_stego_embedder lse_checker u_lse_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready)
);
`default_nettype wire
